### rtl/cartridge_bank_mapper_top_assert.svh
`ifndef CARTRIDGE_BANK_MAPPER_TOP_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_TOP_ASSERT_SVH

// clocked check, held off while reset is low
`define CBM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define CBM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cbm_pkg.sv
package cbm_pkg;

    localparam int ROM_LOW_W  = 7;
    localparam int ROM_HIGH_W = 2;
    localparam int RAM_BANK_W = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int PHYS_W     = 21;
    localparam int ROM_OFS_W  = 14;
    localparam int RAM_OFS_W  = 13;

    typedef enum logic [1:0] {
        KIND_ROM_ONLY = 2'd0,
        KIND_MBC1     = 2'd1,
        KIND_MBC2     = 2'd2,
        KIND_MBC35    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        TGT_NONE      = 2'd0,
        TGT_ROM_READ  = 2'd1,
        TGT_RAM_READ  = 2'd2,
        TGT_RAM_WRITE = 2'd3
    } target_t;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] REGION_RAM_EN   = 2'd0;
    localparam logic [1:0] REGION_ROM_BANK = 2'd1;
    localparam logic [1:0] REGION_RAM_BANK = 2'd2;
    localparam logic [1:0] REGION_MODE     = 2'd3;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;

    typedef struct packed {
        logic [ROM_LOW_W-1:0]  rom_bank_low;
        logic [ROM_HIGH_W-1:0] rom_bank_high;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  ram_enable;
        logic                  bank_mode;
    } bank_state_t;

endpackage

### rtl/cbm_bank_regs.sv
module cbm_bank_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_wdata,
    input  logic                       upd,
    input  logic                       op,
    input  logic [cbm_pkg::ADDR_W-1:0] addr,
    input  logic [cbm_pkg::DATA_W-1:0] wdata,
    output cbm_pkg::bank_state_t       state,
    output logic                       ram_on_next
);
    import cbm_pkg::*;

    kind_t       kind_reg;
    bank_state_t bank_reg;
    bank_state_t bank_next;
    logic [ROM_LOW_W-1:0] nb;
    logic                 take;

    always_comb begin
        bank_next = bank_reg;
        nb        = '0;
        take      = 1'b0;
        if (upd && op == OP_WRITE && !addr[15]) begin
            unique case (addr[14:13])
                REGION_RAM_EN: begin
                    take = (kind_reg == KIND_MBC1) || (kind_reg == KIND_MBC35) ||
                           (kind_reg == KIND_MBC2 && !addr[4]);
                    if (take) begin
                        bank_next.ram_enable = (wdata[3:0] == RAM_EN_KEY);
                    end
                end
                REGION_ROM_BANK: begin
                    unique case (kind_reg)
                        KIND_MBC1: begin
                            nb   = {2'b00, wdata[4:0]};
                            take = 1'b1;
                        end
                        KIND_MBC2: begin
                            nb   = {3'b000, wdata[3:0]};
                            take = addr[4];
                        end
                        KIND_MBC35: begin
                            nb   = wdata[6:0];
                            take = 1'b1;
                        end
                        default: begin
                            nb   = '0;
                            take = 1'b0;
                        end
                    endcase
                    if (take) begin
                        bank_next.rom_bank_low = (nb == '0) ? ROM_LOW_W'(1) : nb;
                    end
                end
                REGION_RAM_BANK: begin
                    if (kind_reg == KIND_MBC1) begin
                        if (bank_reg.bank_mode) begin
                            bank_next.ram_bank = wdata[1:0];
                        end else begin
                            bank_next.rom_bank_high = wdata[1:0];
                        end
                    end
                end
                REGION_MODE: begin
                    bank_next.bank_mode = wdata[0];
                end
                default: begin
                    bank_next = bank_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg               <= KIND_ROM_ONLY;
            bank_reg.rom_bank_low  <= ROM_LOW_W'(1);
            bank_reg.rom_bank_high <= '0;
            bank_reg.ram_bank      <= '0;
            bank_reg.ram_enable    <= 1'b0;
            bank_reg.bank_mode     <= 1'b0;
        end else begin
            if (cfg_we) begin
                kind_reg <= kind_t'(cfg_wdata);
            end
            bank_reg <= bank_next;
        end
    end

    assign state       = bank_reg;
    assign ram_on_next = bank_next.ram_enable;

endmodule

### rtl/cbm_xlate.sv
module cbm_xlate #(
    parameter int ROM_BANK_BITS = 7,
    parameter int RAM_BANK_BITS = 2
) (
    input  cbm_pkg::bank_state_t       state,
    input  logic                       op,
    input  logic [cbm_pkg::ADDR_W-1:0] addr,
    output cbm_pkg::target_t           target,
    output logic [cbm_pkg::PHYS_W-1:0] phys_addr,
    output logic                       ram_disabled_read
);
    import cbm_pkg::*;

    localparam logic [ROM_LOW_W-1:0] RomMask = (ROM_BANK_BITS >= ROM_LOW_W) ?
        {ROM_LOW_W{1'b1}} : ROM_LOW_W'((1 << ROM_BANK_BITS) - 1);
    localparam logic [RAM_BANK_W-1:0] RamMask = (RAM_BANK_BITS >= RAM_BANK_W) ?
        {RAM_BANK_W{1'b1}} : RAM_BANK_W'((1 << RAM_BANK_BITS) - 1);

    logic [ROM_LOW_W-1:0]  rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;

    assign rom_bank = ({state.rom_bank_high, 5'b00000} | state.rom_bank_low) & RomMask;
    assign ram_bank = state.ram_bank & RamMask;

    always_comb begin
        target            = TGT_NONE;
        phys_addr         = '0;
        ram_disabled_read = 1'b0;
        if (!addr[15]) begin
            if (op == OP_READ) begin
                target = TGT_ROM_READ;
                if (!addr[14]) begin
                    phys_addr = PHYS_W'(addr[ROM_OFS_W-1:0]);
                end else begin
                    phys_addr = {rom_bank, addr[ROM_OFS_W-1:0]};
                end
            end
        end else if (addr[15:13] == 3'b101) begin
            if (state.ram_enable) begin
                target    = (op == OP_WRITE) ? TGT_RAM_WRITE : TGT_RAM_READ;
                phys_addr = PHYS_W'({ram_bank, addr[RAM_OFS_W-1:0]});
            end else if (op == OP_READ) begin
                ram_disabled_read = 1'b1;
            end
        end
    end

endmodule

### rtl/cartridge_bank_mapper_top.sv
// Cartridge bank mapper. Each word on the s_ channel is one cartridge bus
// access; each yields exactly one result word on the m_ channel, in order.
// Writes below 0x8000 program the RAM enable, ROM bank, RAM bank or upper
// ROM bits and banking mode as the mapper kind (cfg_wdata) decides; ROM
// reads and external RAM accesses come back as a byte offset, tagged in
// m_tuser. An access passes an input register and a result register; a new
// one is taken every cycle unless m_tready stalls the result. The bank
// registers are updated as an access moves into the result register, which
// keeps each result in step with the accesses before it. The user must rewrite
// mapper_kind only while the block holds no access; the block does not enforce it.
module cartridge_bank_mapper_top #(
    parameter int ROM_BANK_BITS = 7,
    parameter int RAM_BANK_BITS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,    // mapper_kind
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // bus_addr[15:0], wdata[23:16]
    input  logic        s_tuser,      // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // phys_addr[20:0], ram_disabled_read, ram_on, zero
    output logic [1:0]  m_tuser       // target
);
    import cbm_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic              in_op_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [DATA_W-1:0] in_wdata_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    target_t           out_target_reg;
    logic [PHYS_W-1:0] out_phys_reg;
    logic              out_dis_reg;
    logic              out_ram_on_reg;

    logic              out_free;
    logic              advance;
    bank_state_t       state;
    logic              ram_on_next;
    target_t           target;
    logic [PHYS_W-1:0] phys_addr;
    logic              ram_disabled_read;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    cbm_bank_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .upd         (advance),
        .op          (in_op_reg),
        .addr        (in_addr_reg),
        .wdata       (in_wdata_reg),
        .state       (state),
        .ram_on_next (ram_on_next)
    );

    cbm_xlate #(
        .ROM_BANK_BITS (ROM_BANK_BITS),
        .RAM_BANK_BITS (RAM_BANK_BITS)
    ) u_xlate (
        .state             (state),
        .op                (in_op_reg),
        .addr              (in_addr_reg),
        .target            (target),
        .phys_addr         (phys_addr),
        .ram_disabled_read (ram_disabled_read)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg    <= s_tuser;
            in_addr_reg  <= s_tdata[ADDR_W-1:0];
            in_wdata_reg <= s_tdata[ADDR_W+DATA_W-1:ADDR_W];
        end
        if (advance) begin
            out_target_reg <= target;
            out_phys_reg   <= phys_addr;
            out_dis_reg    <= ram_disabled_read;
            out_ram_on_reg <= ram_on_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_target_reg;
    assign m_tdata  = {1'b0, out_ram_on_reg, out_dis_reg, out_phys_reg};

endmodule

### rtl/cbm_checker.sv
module cbm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import cbm_pkg::*;

`include "cartridge_bank_mapper_top_assert.svh"

    `CBM_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result word after reset")
    `CBM_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled word changed")
    `CBM_ASSERT(a_none_zero, aclk, aresetn, m_tvalid && m_tuser == TGT_NONE |-> m_tdata[PHYS_W-1:0] == '0, "offset without target")
    `CBM_ASSERT(a_dis_read, aclk, aresetn, m_tvalid && m_tdata[21] |-> m_tuser == TGT_NONE && !m_tdata[22], "disabled read with ram on")
    `CBM_ASSERT(a_ram_on, aclk, aresetn, m_tvalid && (m_tuser == TGT_RAM_READ || m_tuser == TGT_RAM_WRITE) |-> m_tdata[22], "ram access while off")

endmodule

bind cartridge_bank_mapper_top cbm_checker u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### verif/tb.sv
`timescale 1ns / 1ps

import cbm_pkg::*;

typedef struct packed {
    target_t          target;
    logic [PHYS_W-1:0] phys;
    logic             dis_read;
    logic             ram_on;
} bus_result_t;

class bank_scoreboard;
    int unsigned rom_bits = 7;
    int unsigned ram_bits = 2;
    kind_t       kind = KIND_ROM_ONLY;
    logic [6:0]  rom_low = 7'd1;
    logic [1:0]  rom_high = 2'd0;
    logic [1:0]  ram_bank = 2'd0;
    logic        ram_en = 1'b0;
    logic        mode = 1'b0;
    bus_result_t result_q[$];
    int          errors = 0;
    int          accepted = 0;
    int          checked = 0;

    function void set_kind(kind_t k);
        kind = k;
    endfunction

    function int pending();
        return result_q.size();
    endfunction

    function void program_register(logic [15:0] addr, logic [7:0] data);
        logic [6:0] nb;
        case (addr[14:13])
            REGION_RAM_EN: begin
                if (kind == KIND_MBC1 || kind == KIND_MBC35 ||
                    (kind == KIND_MBC2 && !addr[4]))
                    ram_en = (data[3:0] == RAM_EN_KEY);
            end
            REGION_ROM_BANK: begin
                if (kind == KIND_ROM_ONLY || (kind == KIND_MBC2 && !addr[4]))
                    return;
                if (kind == KIND_MBC1)
                    nb = {2'b0, data[4:0]};
                else if (kind == KIND_MBC2)
                    nb = {3'b0, data[3:0]};
                else
                    nb = data[6:0];
                rom_low = (nb == 7'd0) ? 7'd1 : nb;
            end
            REGION_RAM_BANK: begin
                if (kind == KIND_MBC1) begin
                    if (mode)
                        ram_bank = data[1:0];
                    else
                        rom_high = data[1:0];
                end
            end
            default: begin
                mode = data[0];
            end
        endcase
    endfunction

    function void note_access(logic op, logic [15:0] addr, logic [7:0] data);
        bus_result_t r;
        int unsigned bank_num;
        r = '{TGT_NONE, '0, 1'b0, 1'b0};
        accepted++;
        if (addr < 16'h8000) begin
            if (op == OP_WRITE) begin
                program_register(addr, data);
            end else if (addr < 16'h4000) begin
                r.target = TGT_ROM_READ;
                r.phys = PHYS_W'(addr);
            end else begin
                bank_num = ((int'(rom_high) << 5) | int'(rom_low)) & ((1 << rom_bits) - 1);
                r.target = TGT_ROM_READ;
                r.phys = PHYS_W'(bank_num * 32'h4000 + (32'(addr) - 32'h4000));
            end
        end else if (addr >= 16'hA000 && addr < 16'hC000) begin
            if (ram_en) begin
                bank_num = int'(ram_bank) & ((1 << ram_bits) - 1);
                r.target = (op == OP_WRITE) ? TGT_RAM_WRITE : TGT_RAM_READ;
                r.phys = PHYS_W'(bank_num * 32'h2000 + (32'(addr) - 32'hA000));
            end else if (op == OP_READ) begin
                r.dis_read = 1'b1;
            end
        end
        r.ram_on = ram_en;
        result_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] tuser, logic [23:0] tdata);
        bus_result_t want;
        if (result_q.size() == 0) begin
            $error("result word with nothing expected: target %0d phys_addr %0h",
                   tuser, tdata[20:0]);
            errors++;
            return;
        end
        want = result_q.pop_front();
        checked++;
        if (tuser !== want.target) begin
            $error("target: expected %0d, got %0d", want.target, tuser);
            errors++;
        end
        if (tdata[20:0] !== want.phys) begin
            $error("phys_addr: expected %0h, got %0h", want.phys, tdata[20:0]);
            errors++;
        end
        if (tdata[21] !== want.dis_read) begin
            $error("ram_disabled_read: expected %0b, got %0b", want.dis_read, tdata[21]);
            errors++;
        end
        if (tdata[22] !== want.ram_on) begin
            $error("ram_on: expected %0b, got %0b", want.ram_on, tdata[22]);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int ROM_BITS = 7;
    localparam int RAM_BITS = 2;
    localparam int CYCLE_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_wdata = 2'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    bank_scoreboard board = new;
    int          cycles = 0;
    logic [8:0]  sink_phase = '0;
    int          settings_run = 0;

    cartridge_bank_mapper_top #(
        .ROM_BANK_BITS(ROM_BITS),
        .RAM_BANK_BITS(RAM_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // both handshakes in one place so a word in and a word out never race
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_access(s_tuser, s_tdata[15:0], s_tdata[23:16]);
            if (m_tvalid && m_tready)
                board.check_result(m_tuser, m_tdata);
        end
    end

    always @(negedge aclk) begin
        sink_phase = sink_phase + 1'b1;
        case (sink_phase[8:7])
            2'd0: m_tready = 1'b1;
            2'd1: m_tready = ($urandom_range(0, 3) != 0);
            2'd2: m_tready = (sink_phase[1:0] == 2'd0);
            default: m_tready = ($urandom_range(0, 1) == 1);
        endcase
    end

    task automatic send_word(input logic op, input logic [15:0] addr, input logic [7:0] data);
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {data, addr};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_kind(input kind_t kind);
        cfg_we = 1'b1;
        cfg_wdata = kind;
        @(negedge aclk);
        cfg_we = 1'b0;
        board.set_kind(kind);
        settings_run++;
    endtask

    task automatic random_access(output logic op, output logic [15:0] addr,
                                 output logic [7:0] data);
        int pick;
        pick = $urandom_range(0, 99);
        data = 8'($urandom_range(0, 255));
        if (pick < 35) begin
            // register write, often with the enable key in the low nibble
            op = OP_WRITE;
            addr = 16'(($urandom_range(0, 3) << 13) | $urandom_range(0, 16'h1FFF));
            if ($urandom_range(0, 1) == 1)
                data = {4'($urandom_range(0, 15)), RAM_EN_KEY};
        end else if (pick < 55) begin
            op = OP_READ;
            addr = 16'($urandom_range(0, 16'h7FFF));
        end else if (pick < 85) begin
            op = 1'($urandom_range(0, 1));
            addr = 16'h A000 + 16'($urandom_range(0, 16'h1FFF));
        end else begin
            op = 1'($urandom_range(0, 1));
            addr = 16'($urandom_range(0, 16'hFFFF));
        end
    endtask

    task automatic run_phase(input kind_t kind, input int count, input int gap_max);
        int left;
        int burst;
        int gap;
        logic op;
        logic [15:0] addr;
        logic [7:0] data;
        drain();
        write_kind(kind);
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0) begin
                random_access(op, addr, data);
                send_word(op, addr, data);
                burst--;
                left--;
            end
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        write_kind(KIND_MBC1);
        send_word(OP_READ, 16'h0000, 8'hFF);
        send_word(OP_READ, 16'h3FFF, 8'h00);
        send_word(OP_READ, 16'h4000, 8'h00);
        send_word(OP_READ, 16'hA000, 8'h00);
        send_word(OP_WRITE, 16'hA000, 8'h55);
        send_word(OP_WRITE, 16'h0000, 8'h0A);
        send_word(OP_WRITE, 16'h2000, 8'h00);
        send_word(OP_WRITE, 16'h3FFF, 8'hFF);
        send_word(OP_WRITE, 16'h4000, 8'h03);
        send_word(OP_READ, 16'h7FFF, 8'h00);
        send_word(OP_WRITE, 16'h6000, 8'h01);
        send_word(OP_WRITE, 16'h5FFF, 8'hFE);
        send_word(OP_READ, 16'hBFFF, 8'h00);
        send_word(OP_WRITE, 16'hA123, 8'hFF);
        send_word(OP_READ, 16'h8000, 8'h00);
        send_word(OP_WRITE, 16'hFFFF, 8'hFF);
        send_word(OP_WRITE, 16'h1FFF, 8'h1B);
        send_word(OP_READ, 16'hC000, 8'h00);
        drain();

        // mbc2 address bit 4 selects between enable and bank
        write_kind(KIND_MBC2);
        send_word(OP_WRITE, 16'h0010, 8'h0A);
        send_word(OP_WRITE, 16'h0000, 8'hFA);
        send_word(OP_WRITE, 16'h2100, 8'h05);
        send_word(OP_WRITE, 16'h2110, 8'h30);
        send_word(OP_WRITE, 16'h4000, 8'h03);
        send_word(OP_READ, 16'h4000, 8'h00);

        run_phase(KIND_MBC1, 113, 4);
        run_phase(KIND_ROM_ONLY, 113, 0);
        run_phase(KIND_MBC2, 113, 8);
        run_phase(KIND_MBC35, 113, 3);
        run_phase(KIND_MBC2, 113, 6);
        run_phase(KIND_MBC1, 113, 2);
        drain();
        repeat (8) @(negedge aclk);

        $display("covered %0d bus accesses under %0d mapper kind settings, %0d results checked",
                 board.accepted, settings_run, board.checked);
        if (board.errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/cbm_pkg.sv
rtl/cbm_bank_regs.sv
rtl/cbm_xlate.sv
rtl/cartridge_bank_mapper_top.sv
rtl/cbm_checker.sv
verif/tb.sv
